// ===== rtl/seeded_lcg_fisher_yates_shuffle_top_macros.svh =====
// Assertion macros for the shuffler controller.
`ifndef SEEDED_LCG_FISHER_YATES_SHUFFLE_TOP_MACROS_SVH
`define SEEDED_LCG_FISHER_YATES_SHUFFLE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SFYS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shuffler assertion failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define SFYS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shuffler assertion failed");

`endif

// ===== rtl/sfys_pkg.sv =====
// Shared types and constants of the deck shuffler.
package sfys_pkg;

  localparam int unsigned DECK_SIZE_DEFAULT = 83;

  localparam int unsigned SEED_W      = 32;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned ENTRY_W     = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASC1   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASC2   = 2'd3;

  // Generator modes; any other code selects the modulo mapping.
  localparam logic [1:0] MODE_PM    = 2'd0;
  localparam logic [1:0] MODE_FLOOR = 2'd1;

  localparam logic [31:0] PM_MOD       = 32'h7FFF_FFFF;
  localparam logic [14:0] PM_MUL       = 15'd16807;
  localparam logic [31:0] LCG_MUL      = 32'd214013;
  localparam logic [31:0] LCG_ADD      = 32'd2531011;
  localparam logic [31:0] LCG_SEED_XOR = 32'd12;

  typedef enum logic {
    REQ_SHUFFLE = 1'b0,
    REQ_READ    = 1'b1
  } sfys_req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SEED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_EMPTY    = 2'd3
  } sfys_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_PASS,
    S_GEN,
    S_RED,
    S_MAP,
    S_MOD,
    S_RD,
    S_WR1,
    S_WR2,
    S_RRD,
    S_RDATA,
    S_DONE
  } sfys_state_e;

  typedef struct packed {
    logic         capture;
    logic         fill_init;
    logic         fill_write;
    logic         pass_init;
    logic         pass_next;
    logic         gen;
    logic         red;
    logic         map;
    logic         mod_step;
    logic         wr1;
    logic         wr2;
    logic         idx_step;
    logic         rrd;
    logic         res_set;
    logic         res_use_data;
    sfys_status_e res_code;
    logic         out_load;
  } sfys_cmd_t;

  typedef struct packed {
    logic req_read;
    logic bad_seed;
    logic pos_oob;
    logic fill_last;
    logic idx_last;
    logic last_pass;
    logic mode_mod;
    logic mod_last;
  } sfys_stat_t;

endpackage

// ===== rtl/sfys_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module sfys_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/sfys_datapath.sv =====
// Datapath: configuration, generator, index mapping, deck memory and result registers.
module sfys_datapath #(
  parameter int unsigned DECK_SIZE = sfys_pkg::DECK_SIZE_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sfys_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfys_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             req_type_i,
  input  logic [sfys_pkg::SEED_W-1:0]      seed_i,
  input  logic [sfys_pkg::POS_W-1:0]       position_i,
  input  sfys_pkg::sfys_cmd_t              cmd_i,
  output sfys_pkg::sfys_stat_t             stat_o,
  output logic [sfys_pkg::ENTRY_W-1:0]     entry_value_o,
  output logic [sfys_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned AW = $clog2(DECK_SIZE);
  localparam int unsigned NW = $clog2(DECK_SIZE + 1);
  localparam int unsigned EW = sfys_pkg::ENTRY_W;
  localparam logic [AW-1:0] IDX_TOP     = AW'(DECK_SIZE - 1);
  localparam logic [AW-1:0] IDX_ONE     = AW'(1);
  localparam logic [AW-1:0] IDX_ASC_END = AW'(DECK_SIZE - 2);
  localparam logic [NW-1:0] N_FULL      = NW'(DECK_SIZE);
  localparam logic [7:0]    POS_LIMIT   = 8'(DECK_SIZE);
  localparam logic [30:0]   PM_MUL_EXT  = 31'(sfys_pkg::PM_MUL);

  logic [1:0]                      mode_q;
  logic [1:0]                      passes_q;
  logic                            asc1_q;
  logic                            asc2_q;
  logic                            req_q;
  logic [sfys_pkg::SEED_W-1:0]     seed_q;
  logic [sfys_pkg::POS_W-1:0]      pos_q;
  logic [31:0]                     gen_q;
  logic [45:0]                     prod_q;
  logic [AW-1:0]                   idx_q;
  logic                            pass_q;
  logic [AW-1:0]                   j_q;
  logic [NW-1:0]                   rem_q;
  logic                            mod_half_q;
  logic [sfys_pkg::ENTRY_W-1:0]    tmp_q;
  logic [sfys_pkg::ENTRY_W-1:0]    res_value_q;
  sfys_pkg::sfys_status_e          res_status_q;
  logic [sfys_pkg::ENTRY_W-1:0]    out_value_q;
  sfys_pkg::sfys_status_e          out_status_q;

  logic                            pm;
  logic                            floor_map;
  logic                            asc;
  logic [NW-1:0]                   i_plus;
  logic [NW-1:0]                   n_span;
  logic [63:0]                     pm_x;
  logic [63+NW:0]                  pm_prod;
  logic [AW-1:0]                   pm_low;
  logic [AW-1:0]                   pm_j;
  logic [14:0]                     lcg_v;
  logic [14+NW:0]                  fl_prod;
  logic [AW-1:0]                   fl_j;
  logic [45:0]                     pm_mul;
  logic [31:0]                     lcg_next;
  logic [32:0]                     red_sum;
  logic [31:0]                     pm_red;
  logic [7:0]                      mod_bits;
  logic [NW-1:0]                   rem_next;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [sfys_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [AW-1:0]                   ram_raddr_a;
  logic [sfys_pkg::ENTRY_W-1:0]    rdata_a;
  logic [sfys_pkg::ENTRY_W-1:0]    rdata_b;

  assign pm        = (mode_q == sfys_pkg::MODE_PM);
  assign floor_map = (mode_q == sfys_pkg::MODE_FLOOR);
  assign asc       = pm && (pass_q ? asc2_q : asc1_q);
  assign i_plus    = NW'(idx_q) + NW'(1);
  assign n_span    = asc ? (N_FULL - NW'(idx_q)) : i_plus;

  // Park-Miller scaled draw: x = s * 0x200000003, j = low + (n * x) >> 64.
  assign pm_x    = {gen_q[30:0], 33'd0} + {32'd0, gen_q} + {31'd0, gen_q, 1'b0};
  assign pm_prod = pm_x * (64'(n_span));
  assign pm_low  = asc ? idx_q : '0;
  assign pm_j    = pm_low + pm_prod[64 +: AW];

  // LCG output and the floor mapping.
  assign lcg_v   = gen_q[30:16];
  assign fl_prod = (15'(lcg_v)) * (15'(i_plus));
  assign fl_j    = fl_prod[15 +: AW];

  assign pm_mul   = gen_q[30:0] * PM_MUL_EXT;
  assign lcg_next = gen_q * sfys_pkg::LCG_MUL + sfys_pkg::LCG_ADD;
  assign red_sum  = {2'd0, prod_q[30:0]} + {18'd0, prod_q[45:31]};
  assign pm_red   = (red_sum >= {1'b0, sfys_pkg::PM_MOD}) ?
                    32'(red_sum - {1'b0, sfys_pkg::PM_MOD}) : red_sum[31:0];

  // Remainder: eight restoring steps per cycle, high byte first.
  assign mod_bits = mod_half_q ? lcg_v[7:0] : {1'b0, lcg_v[14:8]};

  always_comb begin
    logic [NW:0] r;
    r = mod_half_q ? {1'b0, rem_q} : '0;
    for (int k = 7; k >= 0; k--) begin
      r = {r[NW-1:0], mod_bits[k]};
      if (r >= {1'b0, i_plus}) begin
        r = r - {1'b0, i_plus};
      end
    end
    rem_next = r[NW-1:0];
  end

  // Deck memory ports.
  assign ram_we      = cmd_i.fill_write | cmd_i.wr1 | cmd_i.wr2;
  assign ram_waddr   = cmd_i.wr2 ? j_q : idx_q;
  assign ram_wdata   = cmd_i.fill_write ? EW'(idx_q) :
                       (cmd_i.wr1 ? rdata_b : tmp_q);
  assign ram_raddr_a = cmd_i.rrd ? pos_q[AW-1:0] : idx_q;

  sfys_ram #(
    .WIDTH (sfys_pkg::ENTRY_W),
    .DEPTH (DECK_SIZE)
  ) u_deck (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (j_q),
    .rdata_b_o (rdata_b)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sfys_pkg::MODE_PM;
      passes_q   <= 2'd1;
      asc1_q     <= 1'b0;
      asc2_q     <= 1'b0;
      gen_q      <= '0;
      idx_q      <= '0;
      pass_q     <= 1'b0;
      mod_half_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          sfys_pkg::CFG_MODE:   mode_q   <= cfg_data_i;
          sfys_pkg::CFG_PASSES: passes_q <= cfg_data_i;
          sfys_pkg::CFG_ASC1:   asc1_q   <= cfg_data_i[0];
          sfys_pkg::CFG_ASC2:   asc2_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.fill_init) begin
        gen_q  <= pm ? seed_q : (seed_q ^ sfys_pkg::LCG_SEED_XOR);
        idx_q  <= '0;
        pass_q <= 1'b0;
      end
      if (cmd_i.fill_write) begin
        idx_q <= idx_q + IDX_ONE;
      end
      if (cmd_i.pass_init) begin
        idx_q <= asc ? '0 : IDX_TOP;
      end
      if (cmd_i.pass_next) begin
        pass_q <= 1'b1;
      end
      if (cmd_i.idx_step) begin
        idx_q <= asc ? (idx_q + IDX_ONE) : (idx_q - IDX_ONE);
      end
      if (cmd_i.gen && !pm) begin
        gen_q <= lcg_next;
      end
      if (cmd_i.red && pm) begin
        gen_q <= pm_red;
      end
      if (cmd_i.map) begin
        mod_half_q <= 1'b0;
      end
      if (cmd_i.mod_step) begin
        mod_half_q <= !mod_half_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      seed_q <= seed_i;
      pos_q  <= position_i;
    end
    if (cmd_i.gen) begin
      prod_q <= pm_mul;
    end
    if (cmd_i.map) begin
      j_q <= pm ? pm_j : fl_j;
    end
    if (cmd_i.mod_step) begin
      if (mod_half_q) begin
        j_q <= rem_next[AW-1:0];
      end else begin
        rem_q <= rem_next;
      end
    end
    if (cmd_i.wr1) begin
      tmp_q <= rdata_a;
    end
    if (cmd_i.res_set) begin
      res_value_q  <= cmd_i.res_use_data ? rdata_a : '0;
      res_status_q <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign stat_o.req_read  = (req_q == sfys_pkg::REQ_READ);
  assign stat_o.bad_seed  = pm && ((seed_q == '0) || (seed_q >= sfys_pkg::PM_MOD));
  assign stat_o.pos_oob   = ({1'b0, pos_q} >= POS_LIMIT);
  assign stat_o.fill_last = (idx_q == IDX_TOP);
  assign stat_o.idx_last  = asc ? (idx_q == IDX_ASC_END) : (idx_q == IDX_ONE);
  assign stat_o.last_pass = pass_q || !passes_q[1];
  assign stat_o.mode_mod  = !pm && !floor_map;
  assign stat_o.mod_last  = mod_half_q;

  assign entry_value_o = out_value_q;
  assign status_o      = out_status_q;

endmodule

// ===== rtl/sfys_ctrl.sv =====
// Controller: request sequencing, deck-valid flag and result handshake.
`include "seeded_lcg_fisher_yates_shuffle_top_macros.svh"

module sfys_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sfys_pkg::sfys_stat_t stat_i,
  output sfys_pkg::sfys_cmd_t  cmd_o
);

  sfys_pkg::sfys_state_e state_q, state_d;
  logic                  deck_valid_q, deck_valid_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfys_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sfys_pkg::S_DECODE;
      end
      sfys_pkg::S_DECODE: begin
        if (stat_i.req_read) begin
          if (!deck_valid_q || stat_i.pos_oob) state_d = sfys_pkg::S_DONE;
          else state_d = sfys_pkg::S_RRD;
        end else if (stat_i.bad_seed) begin
          state_d = sfys_pkg::S_DONE;
        end else begin
          state_d = sfys_pkg::S_FILL;
        end
      end
      sfys_pkg::S_FILL: begin
        if (stat_i.fill_last) state_d = sfys_pkg::S_PASS;
      end
      sfys_pkg::S_PASS: state_d = sfys_pkg::S_GEN;
      sfys_pkg::S_GEN:  state_d = sfys_pkg::S_RED;
      sfys_pkg::S_RED:  state_d = sfys_pkg::S_MAP;
      sfys_pkg::S_MAP: begin
        state_d = stat_i.mode_mod ? sfys_pkg::S_MOD : sfys_pkg::S_RD;
      end
      sfys_pkg::S_MOD: begin
        if (stat_i.mod_last) state_d = sfys_pkg::S_RD;
      end
      sfys_pkg::S_RD:  state_d = sfys_pkg::S_WR1;
      sfys_pkg::S_WR1: state_d = sfys_pkg::S_WR2;
      sfys_pkg::S_WR2: begin
        if (!stat_i.idx_last) state_d = sfys_pkg::S_GEN;
        else if (stat_i.last_pass) state_d = sfys_pkg::S_DONE;
        else state_d = sfys_pkg::S_PASS;
      end
      sfys_pkg::S_RRD:   state_d = sfys_pkg::S_RDATA;
      sfys_pkg::S_RDATA: state_d = sfys_pkg::S_DONE;
      sfys_pkg::S_DONE: begin
        if (out_free) state_d = sfys_pkg::S_IDLE;
      end
      default: state_d = sfys_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = sfys_pkg::ST_OK;
    in_ready_o     = 1'b0;
    deck_valid_d   = deck_valid_q;
    unique case (state_q)
      sfys_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sfys_pkg::S_DECODE: begin
        if (stat_i.req_read) begin
          if (!deck_valid_q) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = sfys_pkg::ST_EMPTY;
          end else if (stat_i.pos_oob) begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = sfys_pkg::ST_RANGE;
          end
        end else if (stat_i.bad_seed) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = sfys_pkg::ST_BAD_SEED;
        end else begin
          cmd_o.fill_init = 1'b1;
        end
      end
      sfys_pkg::S_FILL: cmd_o.fill_write = 1'b1;
      sfys_pkg::S_PASS: cmd_o.pass_init  = 1'b1;
      sfys_pkg::S_GEN:  cmd_o.gen        = 1'b1;
      sfys_pkg::S_RED:  cmd_o.red        = 1'b1;
      sfys_pkg::S_MAP:  cmd_o.map        = 1'b1;
      sfys_pkg::S_MOD:  cmd_o.mod_step   = 1'b1;
      sfys_pkg::S_RD: ;
      sfys_pkg::S_WR1:  cmd_o.wr1        = 1'b1;
      sfys_pkg::S_WR2: begin
        cmd_o.wr2 = 1'b1;
        if (!stat_i.idx_last) begin
          cmd_o.idx_step = 1'b1;
        end else if (stat_i.last_pass) begin
          cmd_o.res_set = 1'b1;
          deck_valid_d  = 1'b1;
        end else begin
          cmd_o.pass_next = 1'b1;
        end
      end
      sfys_pkg::S_RRD: cmd_o.rrd = 1'b1;
      sfys_pkg::S_RDATA: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_use_data = 1'b1;
      end
      sfys_pkg::S_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sfys_pkg::S_IDLE;
      deck_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      deck_valid_q <= deck_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SFYS_ASSERT_NEXT(a_valid_after_shuffle, (state_q == sfys_pkg::S_WR2) && stat_i.idx_last && stat_i.last_pass, deck_valid_q)
  `SFYS_ASSERT_IMPL(a_read_needs_deck, state_q == sfys_pkg::S_RRD, deck_valid_q)
  `SFYS_ASSERT_IMPL(a_mod_only_modulo, state_q == sfys_pkg::S_MOD, stat_i.mode_mod)

endmodule

// ===== rtl/seeded_lcg_fisher_yates_shuffle_top.sv =====
// Top level of the seeded Fisher-Yates deck shuffler.
//
// A shuffle request (tuser 0) loads the deck with 0..DECK_SIZE-1 and runs one or
// two Fisher-Yates passes from one continuing generator: the minimal standard
// Park-Miller generator with fixed-point scaling in mode 0 (passes ascending or
// descending, seed must be 1..2^31-2), or the 214013/2531011 LCG seeded with
// seed^12 in modes 1 (floor map) and 2 or 3 (modulo map). A read request (tuser 1)
// returns one deck entry. Every request gives exactly one result. One request
// is worked at a time; a new one is taken while the last result still waits
// on the output register. Each swap step of a shuffle pass is a generator
// multiply, a reduce, an index map (plus two remainder steps in modes 2 and 3),
// one read of both entries and two writes on the single write port of the
// deck memory. A read passes through decode, a deck read, a data capture and
// the done state; an error goes from decode straight to done.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this.
module seeded_lcg_fisher_yates_shuffle_top #(
  parameter int unsigned DECK_SIZE = sfys_pkg::DECK_SIZE_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfys_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sfys_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] seed, [38:32] position, [39] zero
  input  logic [sfys_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] req_type
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [6:0] entry_value, [8:7] status, [15:9] zero
  output logic [sfys_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  sfys_pkg::sfys_cmd_t              cmd;
  sfys_pkg::sfys_stat_t             stat;
  logic [sfys_pkg::ENTRY_W-1:0]     entry_value;
  logic [sfys_pkg::STATUS_W-1:0]    status;

  // Sequence each request; hold the result until the sink takes it.
  sfys_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Generator, index mapping and deck memory.
  sfys_datapath #(
    .DECK_SIZE (DECK_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (s_axis_tuser),
    .seed_i        (s_axis_tdata[31:0]),
    .position_i    (s_axis_tdata[38:32]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_value_o (entry_value),
    .status_o      (status)
  );

  // Pack the result; upper bits stay zero.
  assign m_axis_tdata = {7'd0, status, entry_value};

endmodule
